// ===== rtl/core/running_rms_level_detector_defines.svh =====
// Assertion macros for the RTL.
`ifndef RUNNING_RMS_LEVEL_DETECTOR_DEFINES_SVH
`define RUNNING_RMS_LEVEL_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge, off while reset is asserted.
`define RRLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define RRLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RRLD_ASSERT(label, prop, msg)

`define RRLD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/core/rrld_pkg.sv =====
package rrld_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int NUM_CHANNELS = 2;

    // config register widths and indexes
    localparam int WF_W        = 16;
    localparam int CC_W        = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_FRAMES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;
    localparam logic [WF_W-1:0] WF_RESET = 16'd480;
    localparam logic [CC_W-1:0] CC_RESET = 2'd2;

    // datapath widths
    localparam int CH_W     = 1;
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MS_W     = 32;
    localparam int LEVEL_W  = 16;
    localparam int N_W      = WF_W + CC_W;
    localparam int ACC_W    = MS_W + N_W;    // ms*(n-1)+sq <= (2^32-1)*n
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int WIDE_W   = 64;
    localparam int SQ_FRAC  = 2 * (SAMPLE_BITS - 1);
    localparam int SQ_RSHIFT = (SQ_FRAC >= MS_W) ? (SQ_FRAC - MS_W) : 0;
    localparam int SQ_LSHIFT = (SQ_FRAC < MS_W) ? (MS_W - SQ_FRAC) : 0;
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // iteration counts
    localparam int DIV_STEPS  = MS_W;
    localparam int SQRT_STEPS = MS_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int SQRT_IDX_W = $clog2(SQRT_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    typedef struct packed {
        logic             load_in;
        logic             square;
        logic             mac;
        logic             div_step;
        logic             write_back;
        logic             sqrt_step;
        logic             out_load;
        logic [CNT_W-1:0] step_idx;
    } cmd_t;

endpackage

// ===== rtl/core/rrld_if.sv =====
interface rrld_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rrld_pkg::SAMPLE_BITS-1:0]  sample_value;
    logic        [rrld_pkg::CH_W-1:0]         channel_index;

    modport source (output valid, output sample_value, output channel_index, input ready);
    modport sink   (input valid, input sample_value, input channel_index, output ready);
endinterface

interface rrld_level_if;
    logic                             valid;
    logic                             ready;
    logic [rrld_pkg::LEVEL_W-1:0]     rms_level;
    logic [rrld_pkg::CH_W-1:0]        level_channel;

    modport source (output valid, output rms_level, output level_channel, input ready);
    modport sink   (input valid, input rms_level, input level_channel, output ready);
endinterface

// ===== rtl/core/rrld_datapath.sv =====
module rrld_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  rrld_pkg::cmd_t                          cmd,
    input  logic        [rrld_pkg::WF_W-1:0]        window_frames,
    input  logic        [rrld_pkg::CC_W-1:0]        channel_count,
    input  logic signed [rrld_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic        [rrld_pkg::CH_W-1:0]        channel_index,
    output logic        [rrld_pkg::LEVEL_W-1:0]     rms_level,
    output logic        [rrld_pkg::CH_W-1:0]        level_channel
);
    import rrld_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [N_W-1:0]         n_reg;
    logic [MS_W-1:0]        sq_reg;
    logic [N_W-1:0]         rem_reg;
    logic [MS_W-1:0]        quo_reg;
    logic [MS_W-1:0]        sqrt_rem_reg;
    logic [MS_W-1:0]        root_reg;
    logic [MS_W-1:0]        ms_reg [NUM_CHANNELS];
    logic [LEVEL_W-1:0]     rms_level_reg;
    logic [CH_W-1:0]        level_channel_reg;

    logic                   ch_valid;
    logic [CH_IDX_W-1:0]    ch_idx;
    logic [N_W-1:0]         n_raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      sq_prod;
    logic [WIDE_W-1:0]      sq_wide;
    logic [MS_W-1:0]        sq_sat;
    logic [ACC_W-1:0]       acc;
    logic [N_W:0]           rem_sh;
    logic                   q_bit;
    logic [MS_W-1:0]        sqrt_bit;
    logic [MS_W-1:0]        sqrt_trial;
    logic                   sqrt_take;

    assign ch_valid = (32'(ch_reg) < NUM_CHANNELS);
    assign ch_idx   = CH_IDX_W'(ch_reg);
    assign n_raw    = N_W'(window_frames) * N_W'(channel_count);

    // |x|^2 in Q0.32, saturating; full-scale negative saturates to 2^32-1
    assign mag     = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign sq_prod = mag * mag;
    assign sq_wide = (WIDE_W'(sq_prod) >> SQ_RSHIFT) << SQ_LSHIFT;
    assign sq_sat  = (sq_wide > WIDE_W'(MS_MAX)) ? MS_MAX : sq_wide[MS_W-1:0];

    assign acc = ACC_W'(ms_reg[ch_idx]) * ACC_W'(n_reg - 1'b1) + ACC_W'(sq_reg);

    // restoring divide, one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[MS_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, n_reg});

    // square root, two radicand bits per step
    assign sqrt_bit   = MS_W'(1) << {cmd.step_idx[SQRT_IDX_W-1:0], 1'b0};
    assign sqrt_trial = root_reg + sqrt_bit;
    assign sqrt_take  = (sqrt_rem_reg >= sqrt_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= sample_value;
            ch_reg     <= channel_index;
            n_reg      <= (n_raw == '0) ? N_W'(1) : n_raw;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_sat;
        end
        if (cmd.mac)
        begin
            rem_reg <= N_W'(acc >> MS_W);
            quo_reg <= acc[MS_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? N_W'(rem_sh - {1'b0, n_reg}) : N_W'(rem_sh);
            quo_reg <= {quo_reg[MS_W-2:0], q_bit};
        end
        if (cmd.write_back)
        begin
            sqrt_rem_reg <= quo_reg;
            root_reg     <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (sqrt_take)
            begin
                sqrt_rem_reg <= sqrt_rem_reg - sqrt_trial;
                root_reg     <= (root_reg >> 1) + sqrt_bit;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
        if (cmd.out_load)
        begin
            rms_level_reg     <= ch_valid ? root_reg[LEVEL_W-1:0] : '0;
            level_channel_reg <= ch_reg;
        end
    end

    // running mean square per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ms_reg[i] <= '0;
            end
        end
        else if (cmd.write_back && ch_valid)
        begin
            ms_reg[ch_idx] <= quo_reg;
        end
    end

    assign rms_level     = rms_level_reg;
    assign level_channel = level_channel_reg;

endmodule

// ===== rtl/core/rrld_ctrl.sv =====
`include "running_rms_level_detector_defines.svh"

module rrld_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output rrld_pkg::cmd_t cmd
);
    import rrld_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step_idx = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac    = 1'b1;
                cnt_next   = DIV_LAST;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                cmd.write_back = 1'b1;
                cnt_next       = SQRT_LAST;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `RRLD_ASSERT(a_div_to_wb, (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_WB), "divide did not end in write-back")
    `RRLD_ASSERT(a_sqrt_start, (state_reg == ST_WB) |=> (state_reg == ST_SQRT && cnt_reg == SQRT_LAST), "square root not started at full count")
    `RRLD_ASSERT(a_done_holds, (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE), "result left while output stalled")
    `RRLD_ASSERT(a_load_valid, cmd.out_load |=> out_valid_reg, "output load without valid")
    `RRLD_ASSERT_ALWAYS(a_one_step, !(cmd.div_step && cmd.sqrt_step), "divide and root stepped together")

endmodule

// ===== rtl/core/running_rms_level_detector.sv =====
// Running RMS level detector. Each accepted sample beat (signed Q1.23 sample plus channel
// number) updates that channel's running mean square, ms = floor((ms*(N-1) + x^2) / N)
// with N = window_frames * channel_count (taken as 1 when zero), and returns one level beat
// carrying floor(sqrt(ms)) as unsigned Q0.16 with the channel number. The square saturates
// at 2^32-1 in Q0.32. Each item is registered on acceptance, then squared, multiplied and
// accumulated, run through the bit-per-cycle restoring divider, written back, run through
// the two-bits-per-cycle square root and loaded into the output register once any earlier
// level is taken. The next sample can be taken in the same cycle as that level beat
// appears. The output register holds a finished level until it is taken; a new sample
// is accepted only when the datapath is idle. Config registers (index 0 window_frames,
// index 1 channel_count) are written with cfg_write_en and may only change while no item
// is in flight. Reset sets window_frames to 480, channel_count to 2 and clears both mean
// squares.
module running_rms_level_detector (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [rrld_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rrld_pkg::CFG_DATA_W-1:0]        cfg_data,
    rrld_sample_if.sink                            samples,
    rrld_level_if.source                           levels
);
    import rrld_pkg::*;

    logic [WF_W-1:0] window_frames_reg;
    logic [CC_W-1:0] channel_count_reg;
    cmd_t            cmd;

    // config registers: only the low bits of each register's width are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_frames_reg <= WF_RESET;
            channel_count_reg <= CC_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_WINDOW_FRAMES: window_frames_reg <= cfg_data[WF_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CC_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer: steps one item through square, accumulate, divide and root
    rrld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (levels.valid),
        .out_ready (levels.ready),
        .cmd       (cmd)
    );

    // arithmetic, per-channel mean square storage and the output register
    rrld_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .window_frames (window_frames_reg),
        .channel_count (channel_count_reg),
        .sample_value  (samples.sample_value),
        .channel_index (samples.channel_index),
        .rms_level     (levels.rms_level),
        .level_channel (levels.level_channel)
    );

endmodule
